FILE: hw/rtl/tsb_pkg.sv
// Shared types, character codes and defaults for the teletype scroll buffer.
package tsb_pkg;

	// Default geometry
	localparam int ROWS_DEF = 4;
	localparam int COLS_DEF = 21;

	// Item function codes
	localparam logic FUNC_FEED = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// Character codes
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LO   = 8'h20;
	localparam logic [7:0] CH_HI   = 8'h7E;
	localparam logic [6:0] CH_DOT  = 7'h2E;

	// Input item
	typedef struct packed {
		logic       func;
		logic [7:0] byte_in;
		logic [1:0] read_row;
		logic [4:0] read_col;
	} in_t;

	// Result item
	typedef struct packed {
		logic [6:0] cell_char;
		logic [4:0] row_length;
		logic [4:0] cursor_column;
		logic       scrolled;
	} out_t;

	// Per-item result from the line control, before the text read returns
	typedef struct packed {
		logic       hit;
		logic [4:0] row_length;
		logic [4:0] cursor_column;
		logic       scrolled;
	} res_t;

	// Map a raw byte to its stored 7-bit character
	function automatic logic [6:0] to_glyph(input logic [7:0] b);
		logic [6:0] g;
		if (b < CH_LO || b > CH_HI) begin
			g = CH_DOT;
		end else begin
			g = b[6:0];
		end
		return g;
	endfunction

endpackage

FILE: hw/rtl/tsb_text_ram.sv
// Character store: one write port, one registered read port.
module tsb_text_ram #(
	parameter int DEPTH = 84,
	parameter int AW    = 7,
	parameter int DW    = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          re,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/tsb_line_ctrl.sv
// Ring pointer, line lengths and cell addressing for one item per cycle while adv is high.
module tsb_line_ctrl #(
	parameter int ROWS = tsb_pkg::ROWS_DEF,
	parameter int COLS = tsb_pkg::COLS_DEF,
	parameter int AW   = 7
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tsb_pkg::in_t   item,
	input  logic           adv,
	output tsb_pkg::res_t  res,
	output logic           we,
	output logic [AW-1:0]  wr_addr,
	output logic [6:0]     wr_data,
	output logic           re,
	output logic [AW-1:0]  rd_addr
);
	import tsb_pkg::*;

	localparam int PTR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LEN_W = $clog2(COLS + 1);
	localparam int SUM_W = PTR_W + 3;

	logic [PTR_W-1:0] top_q;
	logic [LEN_W-1:0] len_q [ROWS];
	logic [LEN_W-1:0] cur_len_q;

	logic             feed, is_lf, is_cr, full, do_scroll, do_write;
	logic [PTR_W-1:0] bottom, wr_slot, rslot, top_nxt;
	logic [LEN_W-1:0] wr_col, new_cur, rlen;
	logic             row_ok, hit;
	logic [SUM_W-1:0] rsum;
	logic [7:0]       rlen_w, cur_w;

	// Feed decode
	always_comb begin
		feed      = (item.func == FUNC_FEED);
		is_lf     = (item.byte_in == CH_LF);
		is_cr     = (item.byte_in == CH_CR);
		bottom    = (top_q == '0) ? PTR_W'(ROWS - 1) : top_q - PTR_W'(1);
		full      = (int'(cur_len_q) >= COLS);
		do_scroll = feed && (is_lf || (!is_cr && full));
		do_write  = feed && !is_lf && !is_cr;
		wr_slot   = do_scroll ? top_q : bottom;
		wr_col    = do_scroll ? '0 : cur_len_q;
		top_nxt   = (int'(top_q) == ROWS - 1) ? '0 : top_q + PTR_W'(1);
		if (do_scroll) begin
			new_cur = do_write ? LEN_W'(1) : '0;
		end else begin
			new_cur = do_write ? cur_len_q + LEN_W'(1) : cur_len_q;
		end
	end

	// Read decode: logical row to physical slot
	always_comb begin
		row_ok = (int'(item.read_row) < ROWS);
		rsum   = SUM_W'(top_q) + SUM_W'(item.read_row);
		if (int'(rsum) >= ROWS) begin
			rsum = rsum - SUM_W'(ROWS);
		end
		rslot  = rsum[PTR_W-1:0];
		rlen   = (!feed && row_ok) ? len_q[rslot] : '0;
		hit    = !feed && row_ok && (int'(item.read_col) < int'(rlen));
	end

	// Result fields, lengths cut to the 5-bit field width
	always_comb begin
		rlen_w            = 8'(rlen);
		cur_w             = 8'(new_cur);
		res.hit           = hit;
		res.row_length    = rlen_w[4:0];
		res.cursor_column = cur_w[4:0];
		res.scrolled      = do_scroll;
	end

	// Text store requests
	assign we      = adv && do_write;
	assign wr_data = to_glyph(item.byte_in);
	assign wr_addr = AW'(int'(wr_slot) * COLS + int'(wr_col));
	assign re      = adv && hit;
	assign rd_addr = AW'(int'(rslot) * COLS + int'(item.read_col));

	// Pointer and length state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= '0;
			cur_len_q <= '0;
			for (int i = 0; i < ROWS; i++) begin
				len_q[i] <= '0;
			end
		end else if (adv && feed && (do_scroll || do_write)) begin
			if (do_scroll) begin
				top_q <= top_nxt;
			end
			len_q[wr_slot] <= new_cur;
			cur_len_q      <= new_cur;
		end
	end

endmodule

FILE: hw/rtl/teletype_scroll_buffer_core.sv
// Teletype scroll buffer: top level with input and result registers.
// Pipeline: the input item is registered, then its result is registered when the
// result register is free; the text store read returns along with that result.
// Throughput: one item per cycle while out_stall does not hold a result; the pointer
// update and one text store access per item set this rate.
// Reset: arst_n clears pointer, line lengths and valid flags; the text store
// holds no reset and is only read inside a row's length.
module teletype_scroll_buffer_core #(
	parameter int ROWS = tsb_pkg::ROWS_DEF,
	parameter int COLS = tsb_pkg::COLS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tsb_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output tsb_pkg::out_t out_data
);
	import tsb_pkg::*;

	localparam int DEPTH = ROWS * COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          valid_s1, valid_s2;
	in_t           item_s1;
	res_t          res, res_s2;
	logic          s2_free, adv, in_xfer;
	logic          we, re;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [6:0]    wr_data, rd_data;

	// Handshake
	assign s2_free  = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_xfer  = in_valid && !in_stall;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer || (valid_s1 && !adv);
			valid_s2 <= adv || (valid_s2 && out_stall);
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_data;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	tsb_line_ctrl #(
		.ROWS (ROWS),
		.COLS (COLS),
		.AW   (AW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.adv     (adv),
		.res     (res),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.re      (re),
		.rd_addr (rd_addr)
	);

	tsb_text_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (7)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.re      (re),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result
	assign out_valid              = valid_s2;
	assign out_data.cell_char     = res_s2.hit ? rd_data : '0;
	assign out_data.row_length    = res_s2.row_length;
	assign out_data.cursor_column = res_s2.cursor_column;
	assign out_data.scrolled      = res_s2.scrolled;

endmodule
